### rtl/sttf_pkg.sv
// Shared widths, types and constants for the four-point sphere block.
`timescale 1ns / 1ps
package sttf_pkg;

   localparam int CW        = 16;            // coordinate width
   localparam int DW        = CW + 1;        // edge vector component
   localparam int XW        = 2 * DW + 2;    // cross product component
   localparam int NRW       = 2 * DW + 2;    // squared edge length
   localparam int HW        = NRW / 2;       // half of a squared length
   localparam int PPW       = HW + 1 + XW;   // half-length times cross component
   localparam int DETW      = DW + XW + 2;   // determinant
   localparam int NW        = NRW + XW + 4;  // numerator of one offset component
   localparam int DENW      = DETW + 1;      // 2 |det|
   localparam int LIMIT_BIT = 33;            // offsets clamp at 2^33
   localparam int QW        = LIMIT_BIT + 2; // quotient bits kept
   localparam int MAGW      = LIMIT_BIT + 1; // clamped offset magnitude
   localparam int OW        = 32;            // output field width
   localparam int SQW       = 2 * OW;        // radicand width
   localparam int RTW       = OW;            // root width
   localparam int SRW       = OW + 2;        // root remainder width

   typedef logic signed [CW-1:0]   coord_type;
   typedef logic signed [DW-1:0]   diff_type;
   typedef logic signed [XW-1:0]   cross_type;
   typedef logic [NRW-1:0]         norm_type;
   typedef logic signed [PPW-1:0]  pp_type;
   typedef logic signed [DETW-1:0] det_type;
   typedef logic signed [NW-1:0]   num_type;
   typedef logic [NW-1:0]          unum_type;
   typedef logic [DENW-1:0]        den_type;
   typedef logic [QW-1:0]          quo_type;
   typedef logic signed [MAGW+1:0] ctr_type;
   typedef logic signed [OW-1:0]   out_type;

   localparam quo_type OFS_LIMIT = quo_type'(1) << LIMIT_BIT;
   localparam logic signed [OW-1:0] I32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [OW-1:0] I32_MIN = 32'sh8000_0000;
   localparam ctr_type CTR_MAX = ctr_type'(I32_MAX);
   localparam ctr_type CTR_MIN = ctr_type'(I32_MIN);

   typedef struct packed {
      logic                 det_zero;
      logic [2:0]           negn;
      logic [2:0][CW-1:0]   p1;
   } div_side_type;

   typedef struct packed {
      logic                 det_zero;
      logic                 flag;
      logic [2:0][OW-1:0]   center;
   } sqrt_side_type;

endpackage

### rtl/sttf_req_if.sv
// Input channel: four points per word.
`timescale 1ns / 1ps
interface sttf_req_if;
   logic valid;
   logic ready;
   logic signed [sttf_pkg::CW-1:0] p1_x, p1_y, p1_z;
   logic signed [sttf_pkg::CW-1:0] p2_x, p2_y, p2_z;
   logic signed [sttf_pkg::CW-1:0] p3_x, p3_y, p3_z;
   logic signed [sttf_pkg::CW-1:0] p4_x, p4_y, p4_z;

   modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
   modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

### rtl/sttf_rsp_if.sv
// Result channel: sphere center, radius and degenerate flag.
`timescale 1ns / 1ps
interface sttf_rsp_if;
   logic valid;
   logic ready;
   logic signed [sttf_pkg::OW-1:0] center_x, center_y, center_z;
   logic [sttf_pkg::OW-1:0]        sphere_radius;
   logic                           degenerate;

   modport source (output valid, center_x, center_y, center_z, sphere_radius, degenerate,
                   input ready);
   modport sink (input valid, center_x, center_y, center_z, sphere_radius, degenerate,
                 output ready);
endinterface

### rtl/sttf_front.sv
// Geometry pipeline: edge vectors, cross products, determinant and offset numerators.
`timescale 1ns / 1ps
module sttf_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [3:0][2:0][sttf_pkg::CW-1:0] pts,
   output logic                             out_valid,
   output logic [2:0][sttf_pkg::NW-1:0]      num,
   output logic [sttf_pkg::DENW-1:0]         den,
   output sttf_pkg::div_side_type            side
);

   function automatic sttf_pkg::cross_type xmul(input sttf_pkg::diff_type x,
                                                input sttf_pkg::diff_type y);
      xmul = x * y;
   endfunction

   function automatic sttf_pkg::det_type dmul(input sttf_pkg::diff_type x,
                                              input sttf_pkg::cross_type y);
      dmul = x * y;
   endfunction

   function automatic sttf_pkg::pp_type pmul(input logic [sttf_pkg::HW-1:0] h,
                                             input sttf_pkg::cross_type x);
      pmul = $signed({1'b0, h}) * x;
   endfunction

   logic [5:0] vld_ff;
   logic [2:0][sttf_pkg::CW-1:0] p1_ff [5];

   // stage 1
   sttf_pkg::diff_type a_ff [3], b_ff [3], c_ff [3];
   sttf_pkg::diff_type a_in [3], b_in [3], c_in [3];
   // stage 2
   sttf_pkg::cross_type cab_ff [3], cca_ff [3], cbc_ff [3];
   sttf_pkg::cross_type cab_in [3], cca_in [3], cbc_in [3];
   sttf_pkg::norm_type  aa_ff, bb_ff, cc_ff, aa_in, bb_in, cc_in;
   sttf_pkg::diff_type  a2_ff [3];
   // stage 3
   sttf_pkg::det_type det3_ff, det3_in;
   sttf_pkg::pp_type  ph_ff [3][3], pl_ff [3][3], ph_in [3][3], pl_in [3][3];
   // stage 4
   sttf_pkg::num_type term_ff [3][3], term_in [3][3];
   sttf_pkg::det_type det4_ff;
   // stage 5
   sttf_pkg::num_type n_ff [3], n_in [3];
   logic [sttf_pkg::DETW-1:0] dabs_ff, dabs_in;
   logic dneg_ff, dz_ff;
   // stage 6
   logic [2:0][sttf_pkg::NW-1:0] num_ff, num_in;
   logic [sttf_pkg::DENW-1:0]    den_ff;
   sttf_pkg::div_side_type       side_ff, side_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in[i] = sttf_pkg::diff_type'(sttf_pkg::coord_type'(pts[1][i]))
                 - sttf_pkg::diff_type'(sttf_pkg::coord_type'(pts[0][i]));
         b_in[i] = sttf_pkg::diff_type'(sttf_pkg::coord_type'(pts[2][i]))
                 - sttf_pkg::diff_type'(sttf_pkg::coord_type'(pts[0][i]));
         c_in[i] = sttf_pkg::diff_type'(sttf_pkg::coord_type'(pts[3][i]))
                 - sttf_pkg::diff_type'(sttf_pkg::coord_type'(pts[0][i]));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cab_in[i] = xmul(a_ff[(i+1)%3], b_ff[(i+2)%3]) - xmul(a_ff[(i+2)%3], b_ff[(i+1)%3]);
         cca_in[i] = xmul(c_ff[(i+1)%3], a_ff[(i+2)%3]) - xmul(c_ff[(i+2)%3], a_ff[(i+1)%3]);
         cbc_in[i] = xmul(b_ff[(i+1)%3], c_ff[(i+2)%3]) - xmul(b_ff[(i+2)%3], c_ff[(i+1)%3]);
      end
      aa_in = sttf_pkg::norm_type'(xmul(a_ff[0], a_ff[0]) + xmul(a_ff[1], a_ff[1])
                                   + xmul(a_ff[2], a_ff[2]));
      bb_in = sttf_pkg::norm_type'(xmul(b_ff[0], b_ff[0]) + xmul(b_ff[1], b_ff[1])
                                   + xmul(b_ff[2], b_ff[2]));
      cc_in = sttf_pkg::norm_type'(xmul(c_ff[0], c_ff[0]) + xmul(c_ff[1], c_ff[1])
                                   + xmul(c_ff[2], c_ff[2]));
   end

   // split each squared length in halves to keep the multipliers narrow
   always_comb begin
      det3_in = dmul(a2_ff[0], cbc_ff[0]) + dmul(a2_ff[1], cbc_ff[1])
              + dmul(a2_ff[2], cbc_ff[2]);
      for (int i = 0; i < 3; i++) begin
         ph_in[i][0] = pmul(cc_ff[sttf_pkg::NRW-1:sttf_pkg::HW], cab_ff[i]);
         pl_in[i][0] = pmul(cc_ff[sttf_pkg::HW-1:0], cab_ff[i]);
         ph_in[i][1] = pmul(bb_ff[sttf_pkg::NRW-1:sttf_pkg::HW], cca_ff[i]);
         pl_in[i][1] = pmul(bb_ff[sttf_pkg::HW-1:0], cca_ff[i]);
         ph_in[i][2] = pmul(aa_ff[sttf_pkg::NRW-1:sttf_pkg::HW], cbc_ff[i]);
         pl_in[i][2] = pmul(aa_ff[sttf_pkg::HW-1:0], cbc_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            term_in[i][j] = (sttf_pkg::num_type'(ph_ff[i][j]) <<< sttf_pkg::HW)
                          + sttf_pkg::num_type'(pl_ff[i][j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = term_ff[i][0] + term_ff[i][1] + term_ff[i][2];
      end
      dabs_in = det4_ff[sttf_pkg::DETW-1] ? -det4_ff : det4_ff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (n_ff[i][sttf_pkg::NW-1] ? -n_ff[i] : n_ff[i])
                   + sttf_pkg::unum_type'(dabs_ff);
         side_in.negn[i] = n_ff[i][sttf_pkg::NW-1] ^ dneg_ff;
      end
      side_in.det_zero = dz_ff;
      side_in.p1       = p1_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
      if (en) begin
         p1_ff[0] <= pts[0];
         for (int s = 1; s < 5; s++) begin
            p1_ff[s] <= p1_ff[s-1];
         end
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         cab_ff  <= cab_in;
         cca_ff  <= cca_in;
         cbc_ff  <= cbc_in;
         aa_ff   <= aa_in;
         bb_ff   <= bb_in;
         cc_ff   <= cc_in;
         a2_ff   <= a_ff;
         det3_ff <= det3_in;
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         term_ff <= term_in;
         det4_ff <= det3_ff;
         n_ff    <= n_in;
         dabs_ff <= dabs_in;
         dneg_ff <= det4_ff[sttf_pkg::DETW-1];
         dz_ff   <= (det4_ff == '0);
         num_ff  <= num_in;
         den_ff  <= {dabs_ff, 1'b0};
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign num       = num_ff;
   assign den       = den_ff;
   assign side      = side_ff;

endmodule

### rtl/sttf_div.sv
// Three-lane restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sttf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [2:0][sttf_pkg::NW-1:0]   num,
   input  logic [sttf_pkg::DENW-1:0]      den,
   input  sttf_pkg::div_side_type         side_in,
   output logic                          out_valid,
   output logic [2:0][sttf_pkg::QW-1:0]   quo,
   output logic [2:0]                    ovf,
   output sttf_pkg::div_side_type         side_out
);

   logic [sttf_pkg::QW-1:0]             vld_ff;
   logic [2:0][sttf_pkg::DENW-1:0]      rem_ff [sttf_pkg::QW], rem_in [sttf_pkg::QW];
   logic [2:0][sttf_pkg::QW-1:0]        low_ff [sttf_pkg::QW], low_in [sttf_pkg::QW];
   logic [2:0][sttf_pkg::QW-1:0]        q_ff [sttf_pkg::QW], q_in [sttf_pkg::QW];
   logic [2:0]                          ovf_ff [sttf_pkg::QW], ovf_in [sttf_pkg::QW];
   logic [sttf_pkg::DENW-1:0]           den_ff [sttf_pkg::QW];
   sttf_pkg::div_side_type              side_ff [sttf_pkg::QW];

   always_comb begin
      logic [sttf_pkg::DENW-1:0] rp;
      logic [sttf_pkg::DENW-1:0] dp;
      logic [sttf_pkg::QW-1:0]   lp;
      logic [sttf_pkg::QW-1:0]   qp;
      logic                      op;
      logic [sttf_pkg::DENW:0]   trial;
      logic [sttf_pkg::DENW:0]   diff;
      logic                      ge;
      for (int s = 0; s < sttf_pkg::QW; s++) begin
         for (int l = 0; l < 3; l++) begin
            if (s == 0) begin
               // quotient at or above 2^QW only flags overflow; the offset clamps anyway
               rp = sttf_pkg::den_type'(num[l][sttf_pkg::NW-1:sttf_pkg::QW]);
               lp = num[l][sttf_pkg::QW-1:0];
               qp = '0;
               op = sttf_pkg::unum_type'(num[l][sttf_pkg::NW-1:sttf_pkg::QW])
                    >= sttf_pkg::unum_type'(den);
               dp = den;
            end else begin
               rp = rem_ff[s-1][l];
               lp = low_ff[s-1][l];
               qp = q_ff[s-1][l];
               op = ovf_ff[s-1][l];
               dp = den_ff[s-1];
            end
            trial = {rp, lp[sttf_pkg::QW-1]};
            diff  = trial - {1'b0, dp};
            ge    = trial >= {1'b0, dp};
            rem_in[s][l] = ge ? diff[sttf_pkg::DENW-1:0] : trial[sttf_pkg::DENW-1:0];
            low_in[s][l] = {lp[sttf_pkg::QW-2:0], 1'b0};
            q_in[s][l]   = {qp[sttf_pkg::QW-2:0], ge};
            ovf_in[s][l] = op;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[sttf_pkg::QW-2:0], in_valid};
      end
      if (en) begin
         rem_ff     <= rem_in;
         low_ff     <= low_in;
         q_ff       <= q_in;
         ovf_ff     <= ovf_in;
         den_ff[0]  <= den;
         side_ff[0] <= side_in;
         for (int s = 1; s < sttf_pkg::QW; s++) begin
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[sttf_pkg::QW-1];
   assign quo       = q_ff[sttf_pkg::QW-1];
   assign ovf       = ovf_ff[sttf_pkg::QW-1];
   assign side_out  = side_ff[sttf_pkg::QW-1];

endmodule

### rtl/sttf_sqrt.sv
// Integer square root, one root bit per stage, remainder kept for rounding.
`timescale 1ns / 1ps
module sttf_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [sttf_pkg::SQW-1:0]    rad,
   input  sttf_pkg::sqrt_side_type     side_in,
   output logic                       out_valid,
   output logic [sttf_pkg::RTW-1:0]    root,
   output logic [sttf_pkg::SRW-1:0]    rem,
   output sttf_pkg::sqrt_side_type     side_out
);

   logic [sttf_pkg::RTW-1:0] vld_ff;
   logic [sttf_pkg::SQW-1:0] x_ff [sttf_pkg::RTW], x_in [sttf_pkg::RTW];
   logic [sttf_pkg::RTW-1:0] root_ff [sttf_pkg::RTW], root_in [sttf_pkg::RTW];
   logic [sttf_pkg::SRW-1:0] rem_ff [sttf_pkg::RTW], rem_in [sttf_pkg::RTW];
   sttf_pkg::sqrt_side_type  side_ff [sttf_pkg::RTW];

   always_comb begin
      logic [sttf_pkg::SQW-1:0] xp;
      logic [sttf_pkg::RTW-1:0] tp;
      logic [sttf_pkg::SRW-1:0] rp;
      logic [sttf_pkg::SRW+1:0] cur;
      logic [sttf_pkg::SRW+1:0] trial;
      logic [sttf_pkg::SRW+1:0] diff;
      logic                     ge;
      for (int s = 0; s < sttf_pkg::RTW; s++) begin
         if (s == 0) begin
            xp = rad;
            tp = '0;
            rp = '0;
         end else begin
            xp = x_ff[s-1];
            tp = root_ff[s-1];
            rp = rem_ff[s-1];
         end
         cur   = {rp, xp[sttf_pkg::SQW-1:sttf_pkg::SQW-2]};
         trial = '0;
         trial[sttf_pkg::RTW+1:0] = {tp, 2'b01};
         diff  = cur - trial;
         ge    = cur >= trial;
         rem_in[s]  = ge ? diff[sttf_pkg::SRW-1:0] : cur[sttf_pkg::SRW-1:0];
         root_in[s] = {tp[sttf_pkg::RTW-2:0], ge};
         x_in[s]    = {xp[sttf_pkg::SQW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[sttf_pkg::RTW-2:0], in_valid};
      end
      if (en) begin
         x_ff       <= x_in;
         root_ff    <= root_in;
         rem_ff     <= rem_in;
         side_ff[0] <= side_in;
         for (int s = 1; s < sttf_pkg::RTW; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[sttf_pkg::RTW-1];
   assign root      = root_ff[sttf_pkg::RTW-1];
   assign rem       = rem_ff[sttf_pkg::RTW-1];
   assign side_out  = side_ff[sttf_pkg::RTW-1];

endmodule

### rtl/sphere_through_four_points_top.sv
// Top level of the sphere-through-four-points pipeline.
`timescale 1ns / 1ps
// Usage:
//  req_in carries four 3D points (signed, 8 fraction bits) per word; rsp_out
//  returns the sphere center, its radius (same scale) and a degenerate flag.
//  Coplanar points give center = first point, radius 0, degenerate set;
//  saturated center or radius also sets degenerate.
//  Stages: 6 geometry stages, 35 divider stages (one quotient bit each), 3
//  offset/square stages, 32 root stages (one root bit each) and the output
//  register.
//  Throughput: one word per cycle unless stalled; every stage is a register with a valid bit.
//  Stall: the whole pipeline advances only when the output register is empty
//  or taken, so req_in.ready follows rsp_out.ready combinationally while the
//  output holds a result; nothing is dropped or repeated.
//  Reset (synchronous, active high) clears all valid bits; data in flight is
//  discarded and the block accepts a word in the first cycle after reset.
module sphere_through_four_points_top (
   input logic         clock,
   input logic         reset,
   sttf_req_if.sink    req_in,
   sttf_rsp_if.source  rsp_out
);

   logic en;
   logic [3:0][2:0][sttf_pkg::CW-1:0] pts;

   logic                              f_valid;
   logic [2:0][sttf_pkg::NW-1:0]      f_num;
   logic [sttf_pkg::DENW-1:0]         f_den;
   sttf_pkg::div_side_type            f_side;

   logic                              d_valid;
   logic [2:0][sttf_pkg::QW-1:0]      d_quo;
   logic [2:0]                        d_ovf;
   sttf_pkg::div_side_type            d_side;

   // offset stage
   logic                              o_valid_ff;
   logic [2:0][sttf_pkg::MAGW-1:0]    mag_ff, mag_in;
   logic [2:0][sttf_pkg::OW-1:0]      ctr_ff, ctr_in;
   logic                              o_flag_ff, o_flag_in, o_dz_ff;
   // square stage
   logic                              s_valid_ff;
   logic [2:0][sttf_pkg::SQW-1:0]     sq_ff, sq_in;
   logic                              s_big_ff;
   sttf_pkg::sqrt_side_type           s_side_ff;
   // sum stage
   logic                              r_valid_ff;
   logic [sttf_pkg::SQW+1:0]          sum;
   logic [sttf_pkg::SQW-1:0]          rad_ff;
   logic                              r_big_ff;
   sttf_pkg::sqrt_side_type           r_side_ff, r_side_in;

   logic                              q_valid;
   logic [sttf_pkg::RTW-1:0]          q_root;
   logic [sttf_pkg::SRW-1:0]          q_rem;
   sttf_pkg::sqrt_side_type           q_side;
   logic                              q_big_ff [sttf_pkg::RTW];

   logic [sttf_pkg::RTW:0]            rnd;
   logic                              big_out;

   logic                              out_valid_ff;
   logic [2:0][sttf_pkg::OW-1:0]      out_ctr_ff;
   logic [sttf_pkg::OW-1:0]           out_rad_ff, out_rad_in;
   logic                              out_deg_ff;

   // advance everything when the output register is free or being taken
   assign en = !out_valid_ff || rsp_out.ready;
   assign req_in.ready = en;

   assign pts[0] = {req_in.p1_z, req_in.p1_y, req_in.p1_x};
   assign pts[1] = {req_in.p2_z, req_in.p2_y, req_in.p2_x};
   assign pts[2] = {req_in.p3_z, req_in.p3_y, req_in.p3_x};
   assign pts[3] = {req_in.p4_z, req_in.p4_y, req_in.p4_x};

   sttf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_in.valid),
      .pts       (pts),
      .out_valid (f_valid),
      .num       (f_num),
      .den       (f_den),
      .side      (f_side)
   );

   sttf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .num       (f_num),
      .den       (f_den),
      .side_in   (f_side),
      .out_valid (d_valid),
      .quo       (d_quo),
      .ovf       (d_ovf),
      .side_out  (d_side)
   );

   // clamp offsets, add to first point, saturate the center
   always_comb begin
      logic              clamp;
      sttf_pkg::quo_type mq;
      sttf_pkg::ctr_type ofs;
      sttf_pkg::ctr_type v;
      o_flag_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         clamp = d_ovf[l] || (d_quo[l] > sttf_pkg::OFS_LIMIT);
         mq    = clamp ? sttf_pkg::OFS_LIMIT : d_quo[l];
         mag_in[l] = mq[sttf_pkg::MAGW-1:0];
         ofs = sttf_pkg::ctr_type'(mq);
         if (d_side.negn[l]) begin
            ofs = -ofs;
         end
         v = sttf_pkg::ctr_type'(sttf_pkg::coord_type'(d_side.p1[l])) + ofs;
         o_flag_in = o_flag_in | clamp;
         if (d_side.det_zero) begin
            ctr_in[l] = sttf_pkg::out_type'(sttf_pkg::coord_type'(d_side.p1[l]));
         end else if (v > sttf_pkg::CTR_MAX) begin
            ctr_in[l] = sttf_pkg::I32_MAX;
            o_flag_in = 1'b1;
         end else if (v < sttf_pkg::CTR_MIN) begin
            ctr_in[l] = sttf_pkg::I32_MIN;
            o_flag_in = 1'b1;
         end else begin
            ctr_in[l] = v[sttf_pkg::OW-1:0];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sq_in[l] = mag_ff[l][sttf_pkg::OW-1:0] * mag_ff[l][sttf_pkg::OW-1:0];
      end
      sum = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      r_side_in = s_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= d_valid;
         s_valid_ff <= o_valid_ff;
         r_valid_ff <= s_valid_ff;
      end
      if (en) begin
         mag_ff    <= mag_in;
         ctr_ff    <= ctr_in;
         o_flag_ff <= o_flag_in;
         o_dz_ff   <= d_side.det_zero;
         sq_ff     <= sq_in;
         // a magnitude of 2^32 or more squares past the radicand range
         s_big_ff  <= (mag_ff[0][sttf_pkg::MAGW-1:sttf_pkg::OW] != '0)
                   || (mag_ff[1][sttf_pkg::MAGW-1:sttf_pkg::OW] != '0)
                   || (mag_ff[2][sttf_pkg::MAGW-1:sttf_pkg::OW] != '0);
         s_side_ff.det_zero <= o_dz_ff;
         s_side_ff.flag     <= o_flag_ff;
         s_side_ff.center   <= ctr_ff;
         rad_ff    <= sum[sttf_pkg::SQW-1:0];
         r_big_ff  <= s_big_ff || (sum[sttf_pkg::SQW+1:sttf_pkg::SQW] != 2'b00);
         r_side_ff <= r_side_in;
      end
   end

   sttf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid_ff),
      .rad       (rad_ff),
      .side_in   (r_side_ff),
      .out_valid (q_valid),
      .root      (q_root),
      .rem       (q_rem),
      .side_out  (q_side)
   );

   // carry the out-of-range mark alongside the root stages
   always_ff @(posedge clock) begin
      if (en) begin
         q_big_ff[0] <= r_big_ff;
         for (int s = 1; s < sttf_pkg::RTW; s++) begin
            q_big_ff[s] <= q_big_ff[s-1];
         end
      end
   end

   // round to nearest from the remainder
   always_comb begin
      rnd     = {1'b0, q_root} + {{sttf_pkg::RTW{1'b0}}, (q_rem > {2'b00, q_root})};
      big_out = q_big_ff[sttf_pkg::RTW-1] || rnd[sttf_pkg::RTW];
      if (q_side.det_zero) begin
         out_rad_in = '0;
      end else if (big_out) begin
         out_rad_in = '1;
      end else begin
         out_rad_in = rnd[sttf_pkg::RTW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= q_valid;
      end
      if (en) begin
         out_ctr_ff <= q_side.center;
         out_rad_ff <= out_rad_in;
         out_deg_ff <= q_side.det_zero || q_side.flag || big_out;
      end
   end

   assign rsp_out.valid         = out_valid_ff;
   assign rsp_out.center_x      = out_ctr_ff[0];
   assign rsp_out.center_y      = out_ctr_ff[1];
   assign rsp_out.center_z      = out_ctr_ff[2];
   assign rsp_out.sphere_radius = out_rad_ff;
   assign rsp_out.degenerate    = out_deg_ff;

endmodule

### rtl/sttf_chk.sv
// Port-level checker for the sphere pipeline, bound to the top level.
`timescale 1ns / 1ps
module sttf_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [sttf_pkg::OW-1:0] center_x,
   input logic [sttf_pkg::OW-1:0] center_y,
   input logic [sttf_pkg::OW-1:0] center_z,
   input logic [sttf_pkg::OW-1:0] sphere_radius,
   input logic                    degenerate
);

   // reset empties the pipeline: no word right after it
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // input side stalls exactly when a held result is not taken
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid || !req_valid |-> (req_ready == (!rsp_valid || rsp_ready)))
      else $error("input ready does not track output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({center_x, center_y, center_z, sphere_radius, degenerate}))
      else $error("result word changed while stalled");

endmodule

bind sphere_through_four_points_top sttf_chk u_sttf_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_in.valid),
   .req_ready     (req_in.ready),
   .rsp_valid     (rsp_out.valid),
   .rsp_ready     (rsp_out.ready),
   .center_x      (rsp_out.center_x),
   .center_y      (rsp_out.center_y),
   .center_z      (rsp_out.center_z),
   .sphere_radius (rsp_out.sphere_radius),
   .degenerate    (rsp_out.degenerate)
);

### test/tb_sphere_through_four_points_top.sv
// Testbench for the four-point sphere pipeline: bit-exact prediction and scoreboard checking.
`timescale 1ns / 1ps
module tb_sphere_through_four_points_top;

   typedef logic signed [191:0] wint_type;

   typedef struct {
      sttf_pkg::coord_type pt[12];
   } points_type;

   typedef struct {
      sttf_pkg::out_type       cx, cy, cz;
      logic [sttf_pkg::OW-1:0] rad;
      logic                    deg;
   } sphere_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sttf_req_if req_bus();
   sttf_rsp_if rsp_bus();

   sphere_through_four_points_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_bus),
      .rsp_out(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sphere_type sphere_queue[$];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   logic       recv_hold = 1'b0;
   int         mismatches = 0;
   int         stall_cycles = 0;

   function automatic sphere_type predict_sphere(points_type p);
      wint_type a[3], b[3], c[3], cab[3], cca[3], cbc[3];
      wint_type aa, bb, cc, det, dabs, den, n, q, acc, ofs[3], v;
      logic     negn, flag, big;
      logic [63:0] s, r, bitv;
      sphere_type res;
      int       j, k;
      flag = 1'b0;
      for (int i = 0; i < 3; i++) begin
         a[i] = wint_type'(p.pt[3 + i]) - wint_type'(p.pt[i]);
         b[i] = wint_type'(p.pt[6 + i]) - wint_type'(p.pt[i]);
         c[i] = wint_type'(p.pt[9 + i]) - wint_type'(p.pt[i]);
      end
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         cab[i] = a[j] * b[k] - a[k] * b[j];
         cca[i] = c[j] * a[k] - c[k] * a[j];
         cbc[i] = b[j] * c[k] - b[k] * c[j];
      end
      aa = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      bb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
      cc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
      det = a[0] * cbc[0] + a[1] * cbc[1] + a[2] * cbc[2];
      if (det == 0) begin
         res.cx = sttf_pkg::out_type'(p.pt[0]);
         res.cy = sttf_pkg::out_type'(p.pt[1]);
         res.cz = sttf_pkg::out_type'(p.pt[2]);
         res.rad = '0;
         res.deg = 1'b1;
         return res;
      end
      dabs = (det < 0) ? -det : det;
      den = dabs + dabs;
      for (int i = 0; i < 3; i++) begin
         n = cc * cab[i] + bb * cca[i] + aa * cbc[i];
         negn = (n < 0) != (det < 0);
         if (n < 0) n = -n;
         // round half away from zero on the magnitude
         q = (n + dabs) / den;
         if (q > wint_type'(sttf_pkg::OFS_LIMIT)) begin
            q = wint_type'(sttf_pkg::OFS_LIMIT);
            flag = 1'b1;
         end
         ofs[i] = negn ? -q : q;
      end
      for (int i = 0; i < 3; i++) begin
         v = wint_type'(p.pt[i]) + ofs[i];
         if (v > wint_type'(sttf_pkg::I32_MAX)) begin
            v = wint_type'(sttf_pkg::I32_MAX);
            flag = 1'b1;
         end
         if (v < wint_type'(sttf_pkg::I32_MIN)) begin
            v = wint_type'(sttf_pkg::I32_MIN);
            flag = 1'b1;
         end
         if (i == 0) res.cx = sttf_pkg::out_type'(v);
         else if (i == 1) res.cy = sttf_pkg::out_type'(v);
         else res.cz = sttf_pkg::out_type'(v);
      end
      acc = ofs[0] * ofs[0] + ofs[1] * ofs[1] + ofs[2] * ofs[2];
      big = (acc >= (wint_type'(1) <<< 64));
      r = 64'hFFFF_FFFF;
      if (!big) begin
         s = acc[63:0];
         r = '0;
         bitv = 64'd1 << 62;
         while (bitv > s) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (s >= r + bitv) begin
               s = s - (r + bitv);
               r = (r >> 1) + bitv;
            end else begin
               r = r >> 1;
            end
            bitv = bitv >> 2;
         end
         if (s > r) r = r + 64'd1;
         if (r > 64'hFFFF_FFFF) big = 1'b1;
      end
      if (big) begin
         r = 64'hFFFF_FFFF;
         flag = 1'b1;
      end
      res.rad = r[sttf_pkg::OW-1:0];
      res.deg = flag;
      return res;
   endfunction

   function automatic points_type make_points(int kind);
      points_type p;
      int         base;
      base = $urandom_range(0, 8191) - 4096;
      for (int i = 0; i < 12; i++) begin
         case (kind)
            0: p.pt[i] = sttf_pkg::coord_type'($urandom);
            1: p.pt[i] = sttf_pkg::coord_type'(base + $urandom_range(0, 2047) - 1024);
            default: p.pt[i] = sttf_pkg::coord_type'($urandom_range(0, 255) - 128);
         endcase
      end
      // nearly coplanar: fourth point close to the plane of the other three
      if (kind == 2) begin
         for (int i = 0; i < 3; i++)
            p.pt[9 + i] = p.pt[3 + i] + p.pt[6 + i] - p.pt[i]
                          + sttf_pkg::coord_type'($urandom_range(0, 2) - 1);
      end
      return p;
   endfunction

   task automatic send_points(points_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      {req_bus.p1_x, req_bus.p1_y, req_bus.p1_z} <= {p.pt[0], p.pt[1], p.pt[2]};
      {req_bus.p2_x, req_bus.p2_y, req_bus.p2_z} <= {p.pt[3], p.pt[4], p.pt[5]};
      {req_bus.p3_x, req_bus.p3_y, req_bus.p3_z} <= {p.pt[6], p.pt[7], p.pt[8]};
      {req_bus.p4_x, req_bus.p4_y, req_bus.p4_z} <= {p.pt[9], p.pt[10], p.pt[11]};
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sphere_queue.insert(sphere_queue.size(), predict_sphere(p));
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (sphere_queue.size() > 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic test_directed();
      points_type p;
      sttf_pkg::coord_type hi, lo;
      hi = sttf_pkg::coord_type'(16'h7FFF);
      lo = sttf_pkg::coord_type'(16'h8000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // all points equal
      foreach (p.pt[i]) p.pt[i] = '0;
      send_points(p);
      foreach (p.pt[i]) p.pt[i] = hi;
      send_points(p);
      foreach (p.pt[i]) p.pt[i] = lo;
      send_points(p);
      // unit corner tetrahedron
      foreach (p.pt[i]) p.pt[i] = '0;
      p.pt[3] = 16'sd256; p.pt[7] = 16'sd256; p.pt[11] = 16'sd256;
      send_points(p);
      // extreme corners of the coordinate range
      foreach (p.pt[i]) p.pt[i] = lo;
      p.pt[3] = hi; p.pt[7] = hi; p.pt[11] = hi;
      send_points(p);
      foreach (p.pt[i]) p.pt[i] = hi;
      p.pt[3] = lo; p.pt[7] = lo; p.pt[11] = lo;
      send_points(p);
      foreach (p.pt[i]) p.pt[i] = (i % 2) ? hi : lo;
      send_points(p);
      // collinear points
      for (int i = 0; i < 12; i++) p.pt[i] = sttf_pkg::coord_type'((i / 3) * 100);
      send_points(p);
      // coplanar square
      foreach (p.pt[i]) p.pt[i] = '0;
      p.pt[3] = 16'sd512; p.pt[7] = 16'sd512; p.pt[9] = 16'sd512; p.pt[10] = 16'sd512;
      send_points(p);
      // nearly flat: huge offset, saturates
      foreach (p.pt[i]) p.pt[i] = '0;
      p.pt[3] = hi; p.pt[7] = hi; p.pt[9] = hi; p.pt[10] = hi; p.pt[11] = 16'sd1;
      send_points(p);
      foreach (p.pt[i]) p.pt[i] = '0;
      p.pt[0] = hi; p.pt[3] = lo; p.pt[7] = hi;
      p.pt[9] = 16'sd1; p.pt[10] = 16'sd1; p.pt[11] = 16'sd1;
      send_points(p);
      for (int i = 0; i < 12; i++) send_points(make_points(i % 3));
      wait_drain();
   endtask

   task automatic test_random(int count, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         int pick;
         pick = $urandom_range(0, 9);
         send_points(make_points(pick < 5 ? 0 : (pick < 8 ? 1 : 2)));
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 120; i++) send_points(make_points(i % 3));
      join
      wait_drain();
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      sphere_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (sphere_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $time);
         end else begin
            want = sphere_queue.pop_front();
            if (rsp_bus.center_x !== want.cx || rsp_bus.center_y !== want.cy ||
                rsp_bus.center_z !== want.cz || rsp_bus.sphere_radius !== want.rad ||
                rsp_bus.degenerate !== want.deg) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp c=(%0d %0d %0d) r=%0d d=%0b",
                           $time, want.cx, want.cy, want.cz, want.rad, want.deg,
                           " got c=(%0d %0d %0d) r=%0d d=%0b",
                           rsp_bus.center_x, rsp_bus.center_y, rsp_bus.center_z,
                           rsp_bus.sphere_radius, rsp_bus.degenerate);
            end
         end
      end
   end

   // watchdog: cycles without any accepted word
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 20000) begin
         $display("tb_sphere_through_four_points_top: FAIL");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      {req_bus.p1_x, req_bus.p1_y, req_bus.p1_z} = '0;
      {req_bus.p2_x, req_bus.p2_y, req_bus.p2_z} = '0;
      {req_bus.p3_x, req_bus.p3_y, req_bus.p3_z} = '0;
      {req_bus.p4_x, req_bus.p4_y, req_bus.p4_z} = '0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200, 23, 85);
      test_random(200, 85, 23);
      wait_drain();
      test_random(80, 0, 0);
      test_backpressure();
      wait_drain();
      if (mismatches == 0 && sphere_queue.size() == 0) begin
         $display("tb_sphere_through_four_points_top: PASS");
      end else begin
         $display("tb_sphere_through_four_points_top: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/sttf_pkg.sv
rtl/sttf_req_if.sv
rtl/sttf_rsp_if.sv
rtl/sttf_front.sv
rtl/sttf_div.sv
rtl/sttf_sqrt.sv
rtl/sphere_through_four_points_top.sv
rtl/sttf_chk.sv
test/tb_sphere_through_four_points_top.sv
